// ===== design/utf8d_pkg.sv =====
// utf8d_pkg: shared types and constants of the UTF-8 byte stream decoder.
// No dependencies; used by utf8d_core, utf8d_out_reg and utf8_byte_stream_decoder.

package utf8d_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 31;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned LEFT_W  = 3;
	localparam int unsigned DATA_W  = 40;   // code_point + char_count, padded to bytes
	localparam int unsigned USER_W  = 1;    // bad_lead

	localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
	localparam logic [BYTE_W-1:0] CONT_MIN   = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_MAX   = 8'hBF;
	localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD5_MIN  = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD6_MIN  = 8'hFC;
	localparam logic [BYTE_W-1:0] BAD_LEAD_MIN = 8'hFE;
	localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_LIMIT_RESET = 8'd48;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic [CP_W-1:0]    code_point;
		logic               bad_lead;
		logic               string_end;
		logic [COUNT_W-1:0] char_count;
	} result_t;

endpackage

// ===== design/utf8_byte_stream_decoder.sv =====
// utf8_byte_stream_decoder: top level of the six-byte UTF-8 string decoder.
// Depends on utf8d_pkg, utf8d_core and utf8d_out_reg.
//
// Usage:
//  - Slave stream (s_tvalid/s_tready/s_tdata) takes one raw string byte per
//    transfer. A NUL byte outside a sequence ends the string.
//  - Master stream (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast) gives one result
//    per completed code point, bad lead byte or string end; m_tlast marks the
//    string end. Lead and middle bytes of a sequence, and non-NUL bytes past
//    char_limit, give no result.
//  - cfg_valid/cfg_data writes char_limit; cfg_ready is always high. Write it
//    only while the block is idle.
//  - Throughput: one byte per cycle while the result register is not stalled. A
//    taken byte passes the input register, then the result register, to m_*.
//  - Reset clears the decode state, empties both registers and sets
//    char_limit to 48.
//  - When the receiver stalls, the result register holds; a byte that makes no
//    result still moves on, and s_tready drops only when a pending byte has a
//    result and the result register is full and not being taken.

module utf8_byte_stream_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [utf8d_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [utf8d_pkg::DATA_W-1:0]      m_tdata,   // [30:0] code_point, [38:31] char_count
	output logic [utf8d_pkg::USER_W-1:0]      m_tuser,   // [0] bad_lead
	output logic                              m_tlast,   // string_end
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [utf8d_pkg::COUNT_W-1:0]     cfg_data   // [7:0] char_limit
);

	logic                           valid_s1;
	logic [utf8d_pkg::BYTE_W-1:0]   byte_s1;
	logic [utf8d_pkg::COUNT_W-1:0]  char_limit_q;
	logic                           has_result;
	logic                           out_free;
	logic                           advance;
	logic                           out_load;
	utf8d_pkg::result_t             result;
	utf8d_pkg::result_t             out_q;

	// Pending byte leaves stage 1 if it makes no result or the result slot frees.
	assign advance  = valid_s1 && (!has_result || out_free);
	assign out_load = advance && has_result;
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			char_limit_q <= utf8d_pkg::CHAR_LIMIT_RESET;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_valid) begin
				char_limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	utf8d_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.data_byte  (byte_s1),
		.char_limit (char_limit_q),
		.has_result (has_result),
		.result     (result)
	);

	utf8d_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (out_load),
		.din     (result),
		.take    (m_tready),
		.free    (out_free),
		.valid_q (m_tvalid),
		.data_q  (out_q)
	);

	assign m_tdata = {1'b0, out_q.char_count, out_q.code_point};
	assign m_tuser = out_q.bad_lead;
	assign m_tlast = out_q.string_end;

	// A new result never overwrites one still waiting downstream.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(m_tvalid && !m_tready))
		else $error("result register overwritten while stalled");

	// String end carries no code point and no bad-lead flag.
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.string_end) |-> (out_q.code_point == '0 && !out_q.bad_lead))
		else $error("string end result with code point or bad flag");

	// Count is only reported on the string end result.
	a_count_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !out_q.string_end) |-> (out_q.char_count == '0))
		else $error("char count on non-end result");

	// Bad lead results carry code point zero.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.bad_lead) |-> (out_q.code_point == '0))
		else $error("bad lead result with nonzero code point");

endmodule

// ===== design/utf8d_core.sv =====
// utf8d_core: decode state (partial code point, bytes left, emitted count) and
// the single-pass next-state / result logic for one byte. Depends on utf8d_pkg.

module utf8d_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  logic [utf8d_pkg::BYTE_W-1:0]     data_byte,
	input  logic [utf8d_pkg::COUNT_W-1:0]    char_limit,
	output logic                             has_result,
	output utf8d_pkg::result_t               result
);

	logic [utf8d_pkg::CP_W-1:0]    partial_q, partial_d;
	logic [utf8d_pkg::LEFT_W-1:0]  left_q, left_d;
	logic [utf8d_pkg::COUNT_W-1:0] count_q, count_d;
	logic [utf8d_pkg::COUNT_W-1:0] count_inc;
	logic [utf8d_pkg::CP_W-1:0]    shifted;

	assign count_inc = count_q + {{(utf8d_pkg::COUNT_W-1){1'b0}},
		(count_q != utf8d_pkg::COUNT_MAX)};
	assign shifted = {partial_q[utf8d_pkg::CP_W-7:0], data_byte[5:0]};

	always_comb begin
		partial_d  = partial_q;
		left_d     = left_q;
		count_d    = count_q;
		has_result = 1'b0;
		result     = '0;
		if (left_q != '0) begin
			// inside a sequence: any byte is a continuation
			partial_d = shifted;
			left_d    = left_q - 3'd1;
			if (left_q == 3'd1) begin
				has_result        = 1'b1;
				result.code_point = shifted;
				count_d           = count_inc;
				partial_d         = '0;
			end
		end else if (data_byte == utf8d_pkg::NUL_BYTE) begin
			has_result        = 1'b1;
			result.string_end = 1'b1;
			result.char_count = count_q;
			count_d           = '0;
			partial_d         = '0;
		end else if (count_q >= char_limit) begin
			// limit reached: drop
		end else if (data_byte <= utf8d_pkg::ASCII_MAX) begin
			has_result        = 1'b1;
			result.code_point = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, data_byte};
			count_d           = count_inc;
		end else if (data_byte inside {[utf8d_pkg::CONT_MIN:utf8d_pkg::CONT_MAX],
				[utf8d_pkg::BAD_LEAD_MIN:8'hFF]}) begin
			has_result      = 1'b1;
			result.bad_lead = 1'b1;
			count_d         = count_inc;
		end else if (data_byte < utf8d_pkg::LEAD3_MIN) begin
			partial_d = {26'd0, data_byte[4:0]};
			left_d    = 3'd1;
		end else if (data_byte < utf8d_pkg::LEAD4_MIN) begin
			partial_d = {27'd0, data_byte[3:0]};
			left_d    = 3'd2;
		end else if (data_byte < utf8d_pkg::LEAD5_MIN) begin
			partial_d = {28'd0, data_byte[2:0]};
			left_d    = 3'd3;
		end else if (data_byte < utf8d_pkg::LEAD6_MIN) begin
			partial_d = {29'd0, data_byte[1:0]};
			left_d    = 3'd4;
		end else begin
			partial_d = {30'd0, data_byte[0]};
			left_d    = 3'd5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			left_q    <= '0;
			count_q   <= '0;
		end else if (fire) begin
			partial_q <= partial_d;
			left_q    <= left_d;
			count_q   <= count_d;
		end
	end

endmodule

// ===== design/utf8d_out_reg.sv =====
// utf8d_out_reg: result register on the master side; holds a result until the
// downstream transfer completes. Depends on utf8d_pkg.

module utf8d_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  utf8d_pkg::result_t din,
	input  logic               take,
	output logic               free,
	output logic               valid_q,
	output utf8d_pkg::result_t data_q
);

	assign free = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule
